// File: design/esc_pkg.sv
package esc_pkg;

	// transaction payloads
	typedef struct packed {
		logic [19:0] raw_temperature;
		logic [19:0] raw_pressure;
		logic [15:0] raw_humidity;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] temperature_centi;
		logic               temperature_valid;
		logic signed [31:0] pressure_q24_8;
		logic [1:0]         pressure_status;
		logic [16:0]        humidity_q22_10;
		logic               humidity_valid;
	} out_item_t;

	// register map, index = paddr / 8
	localparam logic [2:0] REG_TEMP_CALIB  = 3'd0;
	localparam logic [2:0] REG_PRESS_LO    = 3'd1;
	localparam logic [2:0] REG_PRESS_HI    = 3'd2;
	localparam logic [2:0] REG_PRESS_P9    = 3'd3;
	localparam logic [2:0] REG_HUM_CALIB   = 3'd4;
	localparam logic [2:0] REG_FT_OFFSET   = 3'd5;
	localparam logic [2:0] REG_CH_ENABLE   = 3'd6;

	// pressure status codes
	localparam logic [1:0] PST_OK  = 2'd0;
	localparam logic [1:0] PST_OFF = 2'd1;
	localparam logic [1:0] PST_NAN = 2'd2;

	localparam int DW = 64;
	localparam int PCW = 7;

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

	typedef enum logic [3:0] {
		OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_ASR, OP_W32, OP_SAT, OP_CLMP,
		OP_JDIS, OP_JZ, OP_JMP, OP_OUT, OP_NAN, OP_END
	} op_t;

	// operand sources
	localparam logic [4:0] R0 = 5'd0, R1 = 5'd1, R2 = 5'd2, R3 = 5'd3;
	localparam logic [4:0] R4 = 5'd4, R5 = 5'd5, R6 = 5'd6, R7 = 5'd7;
	localparam logic [4:0] S_FT = 5'd8, S_T1 = 5'd9, S_T2 = 5'd10, S_T3 = 5'd11;
	localparam logic [4:0] S_P1 = 5'd12, S_P2 = 5'd13, S_P3 = 5'd14, S_P4 = 5'd15;
	localparam logic [4:0] S_P5 = 5'd16, S_P6 = 5'd17, S_P7 = 5'd18, S_P8 = 5'd19;
	localparam logic [4:0] S_P9 = 5'd20, S_H1 = 5'd21, S_H2 = 5'd22, S_H3 = 5'd23;
	localparam logic [4:0] S_H4 = 5'd24, S_H5 = 5'd25, S_H6 = 5'd26, S_OFF = 5'd27;
	localparam logic [4:0] S_RT = 5'd28, S_RP = 5'd29, S_RH = 5'd30, S_IMM = 5'd31;

	// channel enable bit selects (carried in the a field)
	localparam logic [4:0] EN_TEMP = 5'd0, EN_PRESS = 5'd1, EN_HUM = 5'd2;

	// destinations
	localparam logic [3:0] D0 = 4'd0, D1 = 4'd1, D2 = 4'd2, D3 = 4'd3;
	localparam logic [3:0] D4 = 4'd4, D5 = 4'd5, D6 = 4'd6, D_FT = 4'd8;
	localparam logic [3:0] D_NONE = 4'd15;
	localparam logic [3:0] OUT_TEMP = 4'd0, OUT_PRESS = 4'd1, OUT_HUM = 4'd2;

	// jump targets
	localparam logic [63:0] PC_TEND = 64'd23;
	localparam logic [63:0] PC_PNAN = 64'd60;
	localparam logic [63:0] PC_PEND = 64'd61;
	localparam logic [63:0] PC_END  = 64'd101;

	typedef struct packed {
		op_t         op;
		logic [3:0]  dst;
		logic [4:0]  a;
		logic [4:0]  b;
		logic [63:0] imm;
	} inst_t;

	function automatic inst_t ins(op_t op, logic [3:0] d, logic [4:0] a, logic [4:0] b,
		logic [63:0] imm);
		inst_t i;
		i.op = op;
		i.dst = d;
		i.a = a;
		i.b = b;
		i.imm = imm;
		return i;
	endfunction

	// compensation microprogram
	function automatic inst_t esc_prog(logic [PCW-1:0] pc);
		case (pc)
			// temperature
			7'd0:   return ins(OP_JDIS, D_NONE, EN_TEMP, R0, PC_TEND);
			7'd1:   return ins(OP_ASR, D0, S_RT, R0, 64'd3);
			7'd2:   return ins(OP_MUL, D1, S_T1, S_IMM, 64'd2);
			7'd3:   return ins(OP_SUB, D0, R0, R1, 64'd0);
			7'd4:   return ins(OP_MUL, D0, R0, S_T2, 64'd0);
			7'd5:   return ins(OP_W32, D0, R0, R0, 64'd0);
			7'd6:   return ins(OP_ASR, D0, R0, R0, 64'd11);
			7'd7:   return ins(OP_ASR, D1, S_RT, R0, 64'd4);
			7'd8:   return ins(OP_SUB, D1, R1, S_T1, 64'd0);
			7'd9:   return ins(OP_MUL, D1, R1, R1, 64'd0);
			7'd10:  return ins(OP_W32, D1, R1, R1, 64'd0);
			7'd11:  return ins(OP_ASR, D1, R1, R1, 64'd12);
			7'd12:  return ins(OP_MUL, D1, R1, S_T3, 64'd0);
			7'd13:  return ins(OP_W32, D1, R1, R1, 64'd0);
			7'd14:  return ins(OP_ASR, D1, R1, R1, 64'd14);
			7'd15:  return ins(OP_ADD, D0, R0, R1, 64'd0);
			7'd16:  return ins(OP_ADD, D0, R0, S_OFF, 64'd0);
			7'd17:  return ins(OP_W32, D_FT, R0, R0, 64'd0);
			7'd18:  return ins(OP_MUL, D0, S_FT, S_IMM, 64'd5);
			7'd19:  return ins(OP_ADD, D0, R0, S_IMM, 64'd128);
			7'd20:  return ins(OP_W32, D0, R0, R0, 64'd0);
			7'd21:  return ins(OP_ASR, D0, R0, R0, 64'd8);
			7'd22:  return ins(OP_OUT, OUT_TEMP, R0, R0, 64'd0);
			// pressure
			7'd23:  return ins(OP_JDIS, D_NONE, EN_PRESS, R0, PC_PEND);
			7'd24:  return ins(OP_SUB, D0, S_FT, S_IMM, 64'd128000);
			7'd25:  return ins(OP_MUL, D1, R0, R0, 64'd0);
			7'd26:  return ins(OP_MUL, D2, R1, S_P6, 64'd0);
			7'd27:  return ins(OP_MUL, D3, R0, S_P5, 64'd0);
			7'd28:  return ins(OP_MUL, D3, R3, S_IMM, 64'd131072);
			7'd29:  return ins(OP_ADD, D2, R2, R3, 64'd0);
			7'd30:  return ins(OP_MUL, D3, S_P4, S_IMM, 64'd34359738368);
			7'd31:  return ins(OP_ADD, D2, R2, R3, 64'd0);
			7'd32:  return ins(OP_MUL, D1, R1, S_P3, 64'd0);
			7'd33:  return ins(OP_ASR, D1, R1, R1, 64'd8);
			7'd34:  return ins(OP_MUL, D3, R0, S_P2, 64'd0);
			7'd35:  return ins(OP_MUL, D3, R3, S_IMM, 64'd4096);
			7'd36:  return ins(OP_ADD, D1, R1, R3, 64'd0);
			7'd37:  return ins(OP_ADD, D1, R1, S_IMM, 64'd140737488355328);
			7'd38:  return ins(OP_MUL, D1, R1, S_P1, 64'd0);
			7'd39:  return ins(OP_ASR, D1, R1, R1, 64'd33);
			7'd40:  return ins(OP_JZ, D_NONE, R1, R1, PC_PNAN);
			7'd41:  return ins(OP_SUB, D3, S_IMM, S_RP, 64'd1048576);
			7'd42:  return ins(OP_MUL, D3, R3, S_IMM, 64'd2147483648);
			7'd43:  return ins(OP_SUB, D3, R3, R2, 64'd0);
			7'd44:  return ins(OP_MUL, D3, R3, S_IMM, 64'd3125);
			7'd45:  return ins(OP_DIV, D3, R3, R1, 64'd0);
			7'd46:  return ins(OP_ASR, D4, R3, R3, 64'd13);
			7'd47:  return ins(OP_MUL, D5, S_P9, R4, 64'd0);
			7'd48:  return ins(OP_MUL, D5, R5, R4, 64'd0);
			7'd49:  return ins(OP_ASR, D5, R5, R5, 64'd25);
			7'd50:  return ins(OP_MUL, D6, S_P8, R3, 64'd0);
			7'd51:  return ins(OP_ASR, D6, R6, R6, 64'd19);
			7'd52:  return ins(OP_ADD, D3, R3, R5, 64'd0);
			7'd53:  return ins(OP_ADD, D3, R3, R6, 64'd0);
			7'd54:  return ins(OP_ASR, D3, R3, R3, 64'd8);
			7'd55:  return ins(OP_MUL, D4, S_P7, S_IMM, 64'd16);
			7'd56:  return ins(OP_ADD, D3, R3, R4, 64'd0);
			7'd57:  return ins(OP_SAT, D3, R3, R3, 64'd0);
			7'd58:  return ins(OP_OUT, OUT_PRESS, R3, R3, 64'd0);
			7'd59:  return ins(OP_JMP, D_NONE, R0, R0, PC_PEND);
			7'd60:  return ins(OP_NAN, D_NONE, R0, R0, 64'd0);
			// humidity
			7'd61:  return ins(OP_JDIS, D_NONE, EN_HUM, R0, PC_END);
			7'd62:  return ins(OP_SUB, D0, S_FT, S_IMM, 64'd76800);
			7'd63:  return ins(OP_W32, D0, R0, R0, 64'd0);
			7'd64:  return ins(OP_MUL, D1, S_RH, S_IMM, 64'd16384);
			7'd65:  return ins(OP_MUL, D2, S_H4, S_IMM, 64'd1048576);
			7'd66:  return ins(OP_MUL, D3, S_H5, R0, 64'd0);
			7'd67:  return ins(OP_SUB, D1, R1, R2, 64'd0);
			7'd68:  return ins(OP_SUB, D1, R1, R3, 64'd0);
			7'd69:  return ins(OP_ADD, D1, R1, S_IMM, 64'd16384);
			7'd70:  return ins(OP_W32, D1, R1, R1, 64'd0);
			7'd71:  return ins(OP_ASR, D1, R1, R1, 64'd15);
			7'd72:  return ins(OP_MUL, D2, R0, S_H6, 64'd0);
			7'd73:  return ins(OP_W32, D2, R2, R2, 64'd0);
			7'd74:  return ins(OP_ASR, D2, R2, R2, 64'd10);
			7'd75:  return ins(OP_MUL, D3, R0, S_H3, 64'd0);
			7'd76:  return ins(OP_W32, D3, R3, R3, 64'd0);
			7'd77:  return ins(OP_ASR, D3, R3, R3, 64'd11);
			7'd78:  return ins(OP_ADD, D3, R3, S_IMM, 64'd32768);
			7'd79:  return ins(OP_MUL, D2, R2, R3, 64'd0);
			7'd80:  return ins(OP_W32, D2, R2, R2, 64'd0);
			7'd81:  return ins(OP_ASR, D2, R2, R2, 64'd10);
			7'd82:  return ins(OP_ADD, D2, R2, S_IMM, 64'd2097152);
			7'd83:  return ins(OP_MUL, D2, R2, S_H2, 64'd0);
			7'd84:  return ins(OP_ADD, D2, R2, S_IMM, 64'd8192);
			7'd85:  return ins(OP_W32, D2, R2, R2, 64'd0);
			7'd86:  return ins(OP_ASR, D2, R2, R2, 64'd14);
			7'd87:  return ins(OP_MUL, D3, R1, R2, 64'd0);
			7'd88:  return ins(OP_W32, D3, R3, R3, 64'd0);
			7'd89:  return ins(OP_ASR, D4, R3, R3, 64'd15);
			7'd90:  return ins(OP_MUL, D4, R4, R4, 64'd0);
			7'd91:  return ins(OP_W32, D4, R4, R4, 64'd0);
			7'd92:  return ins(OP_ASR, D4, R4, R4, 64'd7);
			7'd93:  return ins(OP_MUL, D4, R4, S_H1, 64'd0);
			7'd94:  return ins(OP_W32, D4, R4, R4, 64'd0);
			7'd95:  return ins(OP_ASR, D4, R4, R4, 64'd4);
			7'd96:  return ins(OP_SUB, D3, R3, R4, 64'd0);
			7'd97:  return ins(OP_W32, D3, R3, R3, 64'd0);
			7'd98:  return ins(OP_CLMP, D3, R3, R3, 64'd0);
			7'd99:  return ins(OP_ASR, D3, R3, R3, 64'd12);
			7'd100: return ins(OP_OUT, OUT_HUM, R3, R3, 64'd0);
			default: return ins(OP_END, D_NONE, R0, R0, 64'd0);
		endcase
	endfunction

endpackage

// File: design/esc_div.sv
module esc_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [63:0] divisor,
	output logic        done,
	output logic [63:0] quotient
);
	import esc_pkg::*;

	logic        busy_q;
	logic [6:0]  cnt_q;
	logic        neg_q;
	logic [63:0] mag_b_q;
	logic [64:0] rem_q;
	logic [63:0] quot_q;
	logic [64:0] rem_sh;
	logic [64:0] diff;

	// one quotient bit per cycle, restoring
	always_comb begin
		rem_sh = {rem_q[63:0], quot_q[63]};
		diff = rem_sh - {1'b0, mag_b_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'(DW - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[63] ^ divisor[63];
			mag_b_q <= divisor[63] ? (~divisor + 64'd1) : divisor;
			quot_q <= dividend[63] ? (~dividend + 64'd1) : dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!diff[64]) begin
				rem_q <= diff;
				quot_q <= {quot_q[62:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quot_q <= {quot_q[62:0], 1'b0};
			end
		end
	end

	assign quotient = neg_q ? (~quot_q + 64'd1) : quot_q;

endmodule

// File: design/env_sensor_compensation.sv
// channel   | signals                                   | direction
// ----------+-------------------------------------------+----------
// input     | in_valid, in_ready, in_data               | in
// output    | out_valid, out_ready, out_data            | out
// config    | psel, penable, pwrite, paddr, pwdata,     | in/out
//           | prdata, pready (64-bit, register i at 8*i)|
//
// one transaction runs a microprogram on a shared 64-bit add/shift unit, a
// 32x32 multiplier used three times per 64-bit product and a serial divider;
// with all channels on an item runs 69 single steps, 30 three-pass products,
// one divide and the end step in the sequencer. in_ready is high only when
// idle; the result is held in out_data until taken. async reset clears control
// state, the stored fine temperature and the configuration registers to their
// reset values.
module env_sensor_compensation (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  esc_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output esc_pkg::out_item_t  out_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [5:0]          paddr,
	input  logic [63:0]         pwdata,
	output logic [63:0]         prdata,
	output logic                pready
);
	import esc_pkg::*;

	// configuration registers
	logic [47:0] temp_calib_q;
	logic [63:0] press_lo_q;
	logic [63:0] press_hi_q;
	logic [15:0] press_p9_q;
	logic [63:0] hum_calib_q;
	logic [31:0] ft_offset_q;
	logic [2:0]  ch_enable_q;

	state_t state_q, state_d;
	logic [PCW-1:0] pc_q;
	logic [1:0]  mul_cnt_q;
	logic        div_run_q;
	logic [31:0] ft_q;
	logic [63:0] regs_q [8];
	logic [63:0] acc_q;
	in_item_t    raw_q;
	out_item_t   out_q;

	inst_t       inst;
	logic        run;
	logic        accept;
	logic [63:0] src_a, src_b;
	logic [63:0] wr_val;
	logic        wr_en, adv, jmp;
	logic [31:0] mul_x, mul_y;
	logic [63:0] prod;
	logic [63:0] asr_bias;
	logic        div_start, div_done;
	logic [63:0] div_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_calib_q <= '0;
			press_lo_q <= '0;
			press_hi_q <= '0;
			press_p9_q <= '0;
			hum_calib_q <= '0;
			ft_offset_q <= '0;
			ch_enable_q <= 3'd1;
		end else if (cfg_wr) begin
			case (paddr[5:3])
				REG_TEMP_CALIB: temp_calib_q <= pwdata[47:0];
				REG_PRESS_LO:   press_lo_q <= pwdata;
				REG_PRESS_HI:   press_hi_q <= pwdata;
				REG_PRESS_P9:   press_p9_q <= pwdata[15:0];
				REG_HUM_CALIB:  hum_calib_q <= pwdata;
				REG_FT_OFFSET:  ft_offset_q <= pwdata[31:0];
				REG_CH_ENABLE:  ch_enable_q <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		case (paddr[5:3])
			REG_TEMP_CALIB: prdata = {16'd0, temp_calib_q};
			REG_PRESS_LO:   prdata = press_lo_q;
			REG_PRESS_HI:   prdata = press_hi_q;
			REG_PRESS_P9:   prdata = {48'd0, press_p9_q};
			REG_HUM_CALIB:  prdata = hum_calib_q;
			REG_FT_OFFSET:  prdata = {32'd0, ft_offset_q};
			REG_CH_ENABLE:  prdata = {61'd0, ch_enable_q};
			default:        prdata = '0;
		endcase
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_RUN;
			ST_RUN:  if (inst.op == OP_END) state_d = ST_DONE;
			ST_DONE: if (out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_DONE);
	assign out_data = out_q;
	assign accept = in_valid & in_ready;
	assign run = (state_q == ST_RUN);
	assign inst = esc_prog(pc_q);

	// operand selection
	function automatic logic [63:0] pick(logic [4:0] s, logic [63:0] r [8], logic [31:0] ft,
		logic [47:0] tc, logic [63:0] pl, logic [63:0] ph, logic [15:0] p9, logic [63:0] hc,
		logic [31:0] off, in_item_t raw, logic [63:0] imm);
		logic [63:0] v;
		case (s)
			S_FT:  v = {{32{ft[31]}}, ft};
			S_T1:  v = {48'd0, tc[15:0]};
			S_T2:  v = {{48{tc[31]}}, tc[31:16]};
			S_T3:  v = {{48{tc[47]}}, tc[47:32]};
			S_P1:  v = {48'd0, pl[15:0]};
			S_P2:  v = {{48{pl[31]}}, pl[31:16]};
			S_P3:  v = {{48{pl[47]}}, pl[47:32]};
			S_P4:  v = {{48{pl[63]}}, pl[63:48]};
			S_P5:  v = {{48{ph[15]}}, ph[15:0]};
			S_P6:  v = {{48{ph[31]}}, ph[31:16]};
			S_P7:  v = {{48{ph[47]}}, ph[47:32]};
			S_P8:  v = {{48{ph[63]}}, ph[63:48]};
			S_P9:  v = {{48{p9[15]}}, p9};
			S_H1:  v = {56'd0, hc[7:0]};
			S_H2:  v = {{48{hc[23]}}, hc[23:8]};
			S_H3:  v = {56'd0, hc[31:24]};
			S_H4:  v = {{52{hc[43]}}, hc[43:32]};
			S_H5:  v = {{52{hc[55]}}, hc[55:44]};
			S_H6:  v = {{56{hc[63]}}, hc[63:56]};
			S_OFF: v = {{32{off[31]}}, off};
			S_RT:  v = {44'd0, raw.raw_temperature};
			S_RP:  v = {44'd0, raw.raw_pressure};
			S_RH:  v = {48'd0, raw.raw_humidity};
			S_IMM: v = imm;
			default: v = r[s[2:0]];
		endcase
		return v;
	endfunction

	always_comb begin
		src_a = pick(inst.a, regs_q, ft_q, temp_calib_q, press_lo_q, press_hi_q, press_p9_q,
			hum_calib_q, ft_offset_q, raw_q, inst.imm);
		src_b = pick(inst.b, regs_q, ft_q, temp_calib_q, press_lo_q, press_hi_q, press_p9_q,
			hum_calib_q, ft_offset_q, raw_q, inst.imm);
	end

	// shared 32x32 multiplier, three passes per 64-bit product
	always_comb begin
		case (mul_cnt_q)
			2'd0:    begin mul_x = src_a[31:0];  mul_y = src_b[31:0];  end
			2'd1:    begin mul_x = src_a[31:0];  mul_y = src_b[63:32]; end
			default: begin mul_x = src_a[63:32]; mul_y = src_b[31:0];  end
		endcase
		prod = {32'd0, mul_x} * {32'd0, mul_y};
	end

	// shift toward zero for power-of-two division
	assign asr_bias = src_a[63] ? ((64'd1 << inst.imm[5:0]) - 64'd1) : 64'd0;

	// execute
	always_comb begin
		wr_en = 1'b0;
		adv = 1'b0;
		jmp = 1'b0;
		wr_val = src_a + src_b;
		case (inst.op)
			OP_ADD: begin
				wr_en = 1'b1;
				adv = 1'b1;
			end
			OP_SUB: begin
				wr_val = src_a - src_b;
				wr_en = 1'b1;
				adv = 1'b1;
			end
			OP_MUL: begin
				wr_val = acc_q + {prod[31:0], 32'd0};
				if (mul_cnt_q == 2'd2) begin
					wr_en = 1'b1;
					adv = 1'b1;
				end
			end
			OP_DIV: begin
				wr_val = div_q;
				if (div_done) begin
					wr_en = 1'b1;
					adv = 1'b1;
				end
			end
			OP_ASR: begin
				wr_val = 64'($signed(src_a + asr_bias) >>> inst.imm[5:0]);
				wr_en = 1'b1;
				adv = 1'b1;
			end
			OP_W32: begin
				wr_val = {{32{src_a[31]}}, src_a[31:0]};
				wr_en = 1'b1;
				adv = 1'b1;
			end
			OP_SAT: begin
				if ($signed(src_a) < -64'sd2147483648) wr_val = 64'hFFFF_FFFF_8000_0000;
				else if ($signed(src_a) > 64'sd2147483647) wr_val = 64'h0000_0000_7FFF_FFFF;
				else wr_val = src_a;
				wr_en = 1'b1;
				adv = 1'b1;
			end
			OP_CLMP: begin
				if (src_a[63]) wr_val = 64'd0;
				else if (src_a > 64'd419430400) wr_val = 64'd419430400;
				else wr_val = src_a;
				wr_en = 1'b1;
				adv = 1'b1;
			end
			OP_JDIS: begin
				if (!ch_enable_q[inst.a[1:0]]) jmp = 1'b1;
				else adv = 1'b1;
			end
			OP_JZ: begin
				if (src_a == 64'd0) jmp = 1'b1;
				else adv = 1'b1;
			end
			OP_JMP: jmp = 1'b1;
			OP_END: ;
			default: adv = 1'b1;
		endcase
	end

	assign div_start = run && (inst.op == OP_DIV) && !div_run_q;

	esc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (src_a),
		.divisor  (src_b),
		.done     (div_done),
		.quotient (div_q)
	);

	// program counter, unit counters and fine temperature
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
			mul_cnt_q <= '0;
			div_run_q <= 1'b0;
			ft_q <= '0;
		end else if (accept) begin
			pc_q <= '0;
			mul_cnt_q <= '0;
			div_run_q <= 1'b0;
		end else if (run) begin
			if (jmp) pc_q <= inst.imm[PCW-1:0];
			else if (adv) pc_q <= pc_q + 7'd1;
			if (inst.op == OP_MUL) mul_cnt_q <= (mul_cnt_q == 2'd2) ? 2'd0 : mul_cnt_q + 2'd1;
			if (div_start) div_run_q <= 1'b1;
			else if (div_done) div_run_q <= 1'b0;
			if (wr_en && inst.dst == D_FT) ft_q <= wr_val[31:0];
		end
	end

	// working registers and result
	always_ff @(posedge clk) begin
		if (accept) begin
			raw_q <= in_data;
			out_q.temperature_centi <= '0;
			out_q.temperature_valid <= ch_enable_q[0];
			out_q.pressure_q24_8 <= '0;
			out_q.pressure_status <= PST_OFF;
			out_q.humidity_q22_10 <= '0;
			out_q.humidity_valid <= ch_enable_q[2];
		end else if (run) begin
			if (inst.op == OP_MUL) begin
				if (mul_cnt_q == 2'd0) acc_q <= prod;
				else acc_q <= acc_q + {prod[31:0], 32'd0};
			end
			if (wr_en && !inst.dst[3]) regs_q[inst.dst[2:0]] <= wr_val;
			if (inst.op == OP_OUT) begin
				case (inst.dst)
					OUT_TEMP: out_q.temperature_centi <= src_a[31:0];
					OUT_PRESS: begin
						out_q.pressure_q24_8 <= src_a[31:0];
						out_q.pressure_status <= PST_OK;
					end
					OUT_HUM: out_q.humidity_q22_10 <= src_a[16:0];
					default: ;
				endcase
			end
			if (inst.op == OP_NAN) begin
				out_q.pressure_q24_8 <= '0;
				out_q.pressure_status <= PST_NAN;
			end
		end
	end

endmodule
